>>> rtl/motor_q_axis_plant_step_core_assert.svh
// assertion macros for the q-axis plant step core
`ifndef MOTOR_Q_AXIS_PLANT_STEP_CORE_ASSERT_SVH
`define MOTOR_Q_AXIS_PLANT_STEP_CORE_ASSERT_SVH

// condition that must hold in the same cycle as the trigger
`define MQAPS_ASSERT_SAME(name, clk, rstn, trig, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) (trig) |-> (cond)) else $error(msg);

// condition that must hold in the cycle after the trigger
`define MQAPS_ASSERT_NEXT(name, clk, rstn, trig, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) (trig) |=> (cond)) else $error(msg);

`endif

>>> rtl/mqaps_pkg.sv
// shared types, constants and saturating helpers of the q-axis plant step core
`default_nettype none

package mqaps_pkg;

    localparam int unsigned DATA_W     = 32;
    localparam int unsigned GAIN_W     = 31;
    localparam int unsigned ANGLE_W    = 19;
    localparam int unsigned MUL_STEPS  = 31;
    localparam int unsigned WRAP_STEPS = 32;

    // 2*pi in q16, and 2^31 mod 2*pi for the offset-binary modulo
    localparam logic [ANGLE_W-1:0] TWO_PI_Q16 = 19'd411775;
    localparam logic [ANGLE_W-1:0] OFFSET_MOD = 19'd77023;
    localparam logic [ANGLE_W-1:0] WRAP_FIX   = TWO_PI_Q16 - OFFSET_MOD;

    typedef enum logic [2:0] {
        REG_RESISTANCE   = 3'd0,
        REG_CURRENT_STEP = 3'd1,
        REG_BACK_EMF     = 3'd2,
        REG_TORQUE       = 3'd3,
        REG_FRICTION     = 3'd4,
        REG_SPEED_STEP   = 3'd5,
        REG_ANGLE_STEP   = 3'd6
    } reg_index_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_GO,
        ST_MUL_RUN,
        ST_WRAP_GO,
        ST_WRAP_RUN,
        ST_DONE
    } state_t;

    typedef enum logic [2:0] {
        OP_DROP     = 3'd0,
        OP_EMF      = 3'd1,
        OP_CURRENT  = 3'd2,
        OP_TORQUE   = 3'd3,
        OP_FRICTION = 3'd4,
        OP_SPEED    = 3'd5,
        OP_ANGLE    = 3'd6
    } op_t;

    typedef struct packed {
        logic                     start;
        logic signed [DATA_W-1:0] value;
        logic [GAIN_W-1:0]        gain;
    } mul_req_t;

    typedef struct packed {
        logic                     done;
        logic signed [DATA_W-1:0] product;
    } mul_rsp_t;

    typedef struct packed {
        logic                     start;
        logic signed [DATA_W-1:0] value;
    } wrap_req_t;

    typedef struct packed {
        logic               done;
        logic [ANGLE_W-1:0] angle;
    } wrap_rsp_t;

    function automatic logic signed [DATA_W-1:0] sat_add(
        input logic signed [DATA_W-1:0] a,
        input logic signed [DATA_W-1:0] b
    );
        logic signed [DATA_W:0] s;
        s = {a[DATA_W-1], a} + {b[DATA_W-1], b};
        if (s[DATA_W] != s[DATA_W-1]) begin
            sat_add = s[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
        end else begin
            sat_add = s[DATA_W-1:0];
        end
    endfunction

    function automatic logic signed [DATA_W-1:0] sat_sub(
        input logic signed [DATA_W-1:0] a,
        input logic signed [DATA_W-1:0] b
    );
        logic signed [DATA_W:0] s;
        s = {a[DATA_W-1], a} - {b[DATA_W-1], b};
        if (s[DATA_W] != s[DATA_W-1]) begin
            sat_sub = s[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
        end else begin
            sat_sub = s[DATA_W-1:0];
        end
    endfunction

endpackage

`default_nettype wire

>>> rtl/mqaps_mul.sv
// bit-serial q16 multiplier: signed value times unsigned gain, floor shift and saturation
`default_nettype none

module mqaps_mul (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  mqaps_pkg::mul_req_t  req,
    output mqaps_pkg::mul_rsp_t  rsp
);
    import mqaps_pkg::*;

    logic signed [DATA_W:0]   hi_reg, hi_next;
    logic [GAIN_W-1:0]        lo_reg, lo_next;
    logic signed [DATA_W-1:0] mcand_reg, mcand_next;
    logic [4:0]               cnt_reg, cnt_next;
    logic                     busy_reg, busy_next;
    logic                     done_reg, done_next;

    logic signed [DATA_W:0]   addend;
    logic signed [DATA_W:0]   sum;
    logic                     fits;

    always_comb begin
        addend     = lo_reg[0] ? {mcand_reg[DATA_W-1], mcand_reg} : '0;
        sum        = hi_reg + addend;
        hi_next    = hi_reg;
        lo_next    = lo_reg;
        mcand_next = mcand_reg;
        cnt_next   = cnt_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        if (req.start) begin
            hi_next    = '0;
            lo_next    = req.gain;
            mcand_next = req.value;
            cnt_next   = '0;
            busy_next  = 1'b1;
        end else if (busy_reg) begin
            hi_next  = sum >>> 1;
            lo_next  = {sum[0], lo_reg[GAIN_W-1:1]};
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'(MUL_STEPS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        hi_reg    <= hi_next;
        lo_reg    <= lo_next;
        mcand_reg <= mcand_next;
    end

    // full product is {hi, lo}; floor shift by 16 keeps hi[16:0] and lo[30:16]
    assign fits = (&hi_reg[DATA_W:16]) | ~(|hi_reg[DATA_W:16]);

    always_comb begin
        rsp.done = done_reg;
        if (fits) begin
            rsp.product = {hi_reg[16:0], lo_reg[GAIN_W-1:16]};
        end else begin
            rsp.product = hi_reg[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}}
                                         : {1'b0, {(DATA_W-1){1'b1}}};
        end
    end

endmodule

`default_nettype wire

>>> rtl/mqaps_wrap.sv
// bit-serial reduction of a signed q16 angle into [0, 2*pi)
`default_nettype none

module mqaps_wrap (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  mqaps_pkg::wrap_req_t  req,
    output mqaps_pkg::wrap_rsp_t  rsp
);
    import mqaps_pkg::*;

    logic [DATA_W-1:0]  val_reg, val_next;
    logic [ANGLE_W-1:0] rem_reg, rem_next;
    logic [4:0]         cnt_reg, cnt_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;

    logic [ANGLE_W:0]   trial;
    logic [ANGLE_W:0]   diff;

    always_comb begin
        trial     = {rem_reg, val_reg[DATA_W-1]};
        diff      = trial - {1'b0, TWO_PI_Q16};
        val_next  = val_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start) begin
            // offset binary: value plus 2^31, corrected after the reduction
            val_next  = {~req.value[DATA_W-1], req.value[DATA_W-2:0]};
            rem_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            val_next = {val_reg[DATA_W-2:0], 1'b0};
            rem_next = (trial >= {1'b0, TWO_PI_Q16}) ? diff[ANGLE_W-1:0] : trial[ANGLE_W-1:0];
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'(WRAP_STEPS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        val_reg <= val_next;
        rem_reg <= rem_next;
    end

    always_comb begin
        rsp.done = done_reg;
        if (rem_reg >= OFFSET_MOD) begin
            rsp.angle = rem_reg - OFFSET_MOD;
        end else begin
            rsp.angle = rem_reg + WRAP_FIX;
        end
    end

endmodule

`default_nettype wire

>>> rtl/motor_q_axis_plant_step_core.sv
// top level of the q-axis motor plant step core
`default_nettype none

// Simulated PMSM q-axis plant in Q16.16, one forward-Euler step per input word.
// A step word (tuser 0) runs seven q16 products through one bit-serial
// multiplier, then reduces the new angle modulo 2*pi in a bit-serial divider.
// A reset word (tuser 1) clears current and speed and only wraps the angle
// offset. One word is in work at a time; the next word is taken as soon as the
// result sits in the output register, even if the downstream side has not yet
// taken it. Gain registers are to be written through cfg_we/cfg_index/cfg_data
// only while the core is idle; the core itself does not enforce this.
module motor_q_axis_plant_step_core (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [63:0] s_tdata,    // voltage_q [31:0], angle_offset [63:32]
    input  wire  [0:0]  s_tuser,    // kind [0]
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [87:0] m_tdata,    // rotor_angle [18:0], rotor_speed [50:19],
                                    // q_current [82:51], zero [87:83]
    input  wire         cfg_we,
    input  wire  [2:0]  cfg_index,
    input  wire  [30:0] cfg_data
);
    import mqaps_pkg::*;

    logic [GAIN_W-1:0] resistance_gain_reg;
    logic [GAIN_W-1:0] current_step_gain_reg;
    logic [GAIN_W-1:0] back_emf_gain_reg;
    logic [GAIN_W-1:0] torque_gain_reg;
    logic [GAIN_W-1:0] friction_gain_reg;
    logic [GAIN_W-1:0] speed_step_gain_reg;
    logic [GAIN_W-1:0] angle_step_gain_reg;

    state_t                   state_reg, state_next;
    op_t                      op_reg, op_next;
    logic signed [DATA_W-1:0] current_reg, current_next;
    logic signed [DATA_W-1:0] speed_reg, speed_next;
    logic [ANGLE_W-1:0]       angle_reg, angle_next;
    logic signed [DATA_W-1:0] tmp_reg, tmp_next;
    logic signed [DATA_W-1:0] volt_reg, volt_next;
    logic signed [DATA_W-1:0] wrap_in_reg, wrap_in_next;
    logic                     m_valid_reg, m_valid_next;
    logic [87:0]              m_data_reg, m_data_next;

    mul_req_t  mul_req;
    mul_rsp_t  mul_rsp;
    wrap_req_t wrap_req;
    wrap_rsp_t wrap_rsp;

    logic signed [DATA_W-1:0] mul_value;
    logic [GAIN_W-1:0]        mul_gain;

    mqaps_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mul_req),
        .rsp     (mul_rsp)
    );

    mqaps_wrap u_wrap (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (wrap_req),
        .rsp     (wrap_rsp)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            resistance_gain_reg   <= '0;
            current_step_gain_reg <= '0;
            back_emf_gain_reg     <= '0;
            torque_gain_reg       <= '0;
            friction_gain_reg     <= '0;
            speed_step_gain_reg   <= '0;
            angle_step_gain_reg   <= '0;
        end else if (cfg_we) begin
            unique case (reg_index_t'(cfg_index))
                REG_RESISTANCE:   resistance_gain_reg   <= cfg_data;
                REG_CURRENT_STEP: current_step_gain_reg <= cfg_data;
                REG_BACK_EMF:     back_emf_gain_reg     <= cfg_data;
                REG_TORQUE:       torque_gain_reg       <= cfg_data;
                REG_FRICTION:     friction_gain_reg     <= cfg_data;
                REG_SPEED_STEP:   speed_step_gain_reg   <= cfg_data;
                REG_ANGLE_STEP:   angle_step_gain_reg   <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // operand select for the shared multiplier
    always_comb begin
        unique case (op_reg)
            OP_DROP: begin
                mul_value = current_reg;
                mul_gain  = resistance_gain_reg;
            end
            OP_EMF: begin
                mul_value = speed_reg;
                mul_gain  = back_emf_gain_reg;
            end
            OP_CURRENT: begin
                mul_value = tmp_reg;
                mul_gain  = current_step_gain_reg;
            end
            OP_TORQUE: begin
                mul_value = current_reg;
                mul_gain  = torque_gain_reg;
            end
            OP_FRICTION: begin
                mul_value = speed_reg;
                mul_gain  = friction_gain_reg;
            end
            OP_SPEED: begin
                mul_value = tmp_reg;
                mul_gain  = speed_step_gain_reg;
            end
            OP_ANGLE: begin
                mul_value = speed_reg;
                mul_gain  = angle_step_gain_reg;
            end
            default: begin
                mul_value = speed_reg;
                mul_gain  = angle_step_gain_reg;
            end
        endcase
    end

    always_comb begin
        state_next     = state_reg;
        op_next        = op_reg;
        current_next   = current_reg;
        speed_next     = speed_reg;
        angle_next     = angle_reg;
        tmp_next       = tmp_reg;
        volt_next      = volt_reg;
        wrap_in_next   = wrap_in_reg;
        m_data_next    = m_data_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        mul_req.start  = 1'b0;
        mul_req.value  = mul_value;
        mul_req.gain   = mul_gain;
        wrap_req.start = 1'b0;
        wrap_req.value = wrap_in_reg;
        s_tready       = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    if (s_tuser[0]) begin
                        wrap_in_next = s_tdata[63:32];
                        current_next = '0;
                        speed_next   = '0;
                        state_next   = ST_WRAP_GO;
                    end else begin
                        volt_next  = s_tdata[31:0];
                        op_next    = OP_DROP;
                        state_next = ST_MUL_GO;
                    end
                end
            end
            ST_MUL_GO: begin
                mul_req.start = 1'b1;
                state_next    = ST_MUL_RUN;
            end
            ST_MUL_RUN: begin
                if (mul_rsp.done) begin
                    op_next    = op_t'(op_reg + 3'd1);
                    state_next = ST_MUL_GO;
                    unique case (op_reg)
                        OP_DROP:     tmp_next = mul_rsp.product;
                        OP_EMF:      tmp_next = sat_sub(volt_reg,
                                                        sat_add(tmp_reg, mul_rsp.product));
                        OP_CURRENT:  current_next = sat_add(current_reg, mul_rsp.product);
                        OP_TORQUE:   tmp_next = mul_rsp.product;
                        OP_FRICTION: tmp_next = sat_sub(tmp_reg, mul_rsp.product);
                        OP_SPEED:    speed_next = sat_add(speed_reg, mul_rsp.product);
                        OP_ANGLE: begin
                            wrap_in_next = sat_add({{(DATA_W-ANGLE_W){1'b0}}, angle_reg},
                                                   mul_rsp.product);
                            op_next      = OP_DROP;
                            state_next   = ST_WRAP_GO;
                        end
                        default: begin
                            op_next    = OP_DROP;
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_WRAP_GO: begin
                wrap_req.start = 1'b1;
                state_next     = ST_WRAP_RUN;
            end
            ST_WRAP_RUN: begin
                if (wrap_rsp.done) begin
                    angle_next = wrap_rsp.angle;
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    m_data_next  = {5'b0, current_reg, speed_reg, angle_reg};
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            op_reg      <= OP_DROP;
            current_reg <= '0;
            speed_reg   <= '0;
            angle_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            op_reg      <= op_next;
            current_reg <= current_next;
            speed_reg   <= speed_next;
            angle_reg   <= angle_next;
            m_valid_reg <= m_valid_next;
        end
        tmp_reg     <= tmp_next;
        volt_reg    <= volt_next;
        wrap_in_reg <= wrap_in_next;
        m_data_reg  <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

`default_nettype wire

>>> rtl/mqaps_checker.sv
// port-level checks of the q-axis plant step core, bound to the top level
`default_nettype none

`include "motor_q_axis_plant_step_core_assert.svh"

module mqaps_checker (
    input wire        aclk,
    input wire        aresetn,
    input wire        s_tvalid,
    input wire        s_tready,
    input wire        m_tvalid,
    input wire        m_tready,
    input wire [87:0] m_tdata
);
    import mqaps_pkg::*;

    `MQAPS_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "output word changed while stalled")

    `MQAPS_ASSERT_SAME(a_angle_range, aclk, aresetn, m_tvalid, m_tdata[18:0] < TWO_PI_Q16, "rotor angle not wrapped below 2*pi")

    `MQAPS_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_tvalid && s_tready, !s_tready, "input taken again while a word is in work")

    `MQAPS_ASSERT_SAME(a_pad_zero, aclk, aresetn, m_tvalid, m_tdata[87:83] == 5'b0, "output padding bits not zero")

endmodule

bind motor_q_axis_plant_step_core mqaps_checker u_mqaps_checker (.*);

`default_nettype wire
